@@ hw/rtl/nslm_pkg.sv @@
// Shared types and codes for the nested shared lock manager.
// Used by nslm_front, nslm_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package nslm_pkg;

    // Request opcodes
    localparam logic [2:0] OP_OBTAIN_EX   = 3'd0;
    localparam logic [2:0] OP_ATTEMPT_EX  = 3'd1;
    localparam logic [2:0] OP_RELEASE     = 3'd2;
    localparam logic [2:0] OP_OBTAIN_SH   = 3'd3;
    localparam logic [2:0] OP_ATTEMPT_SH  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_HELD    = 3'd3;
    localparam logic [2:0] ST_FREE    = 3'd4;
    localparam logic [2:0] ST_HANDED  = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_CORRUPT = 3'd7;

    // Lock mode codes
    localparam logic [1:0] LM_FREE      = 2'd0;
    localparam logic [1:0] LM_EXCLUSIVE = 2'd1;
    localparam logic [1:0] LM_SHARED    = 2'd2;

    localparam logic [7:0] NEST_MAX = 8'd255;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        K_ACQUIRE = 2'd0,
        K_RELEASE = 2'd1,
        K_BAD     = 2'd2
    } t_kind;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic       shared;
        logic       blocking;
        logic [7:0] task_id;
    } t_req;

    // One result transaction
    typedef struct packed {
        logic [7:0] nest_level;
        logic [1:0] lock_mode;
        logic       woken_shared;
        logic [7:0] woken_task;
        logic       woken_valid;
        logic [2:0] status;
    } t_result;

endpackage

@@ hw/rtl/nslm_front.sv @@
// Front end of the lock manager: decodes each request and queues it.
// Depends on nslm_pkg.
`timescale 1ns / 1ps

module nslm_front
    import nslm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_task_id,
    output logic       o_req_valid,
    output t_req       o_req,
    input  logic       i_req_pop
);

    t_req       w_dec;
    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_dec.task_id  = i_task_id;
        w_dec.shared   = 1'b0;
        w_dec.blocking = 1'b0;
        w_dec.kind     = K_BAD;
        unique case (i_opcode)
            OP_OBTAIN_EX: begin
                w_dec.kind     = K_ACQUIRE;
                w_dec.blocking = 1'b1;
            end
            OP_ATTEMPT_EX: begin
                w_dec.kind = K_ACQUIRE;
            end
            OP_RELEASE: begin
                w_dec.kind = K_RELEASE;
            end
            OP_OBTAIN_SH: begin
                w_dec.kind     = K_ACQUIRE;
                w_dec.shared   = 1'b1;
                w_dec.blocking = 1'b1;
            end
            OP_ATTEMPT_SH: begin
                w_dec.kind   = K_ACQUIRE;
                w_dec.shared = 1'b1;
            end
            default: begin
                w_dec.kind = K_BAD;
            end
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_req_valid = (r_cnt != 2'd0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ hw/rtl/nslm_back.sv @@
// Back end of the lock manager: lock state, waiter queue memory and result register.
// Depends on nslm_pkg.
`timescale 1ns / 1ps

module nslm_back
    import nslm_pkg::*;
#(
    parameter int WAIT_DEPTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_req    i_req,
    output logic    o_req_pop,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FW = $clog2(WAIT_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(WAIT_DEPTH);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(WAIT_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(WAIT_DEPTH - 1);

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_WAKE = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [7:0]    r_owner_task, n_owner_task;
    logic          r_owner_valid, n_owner_valid;
    logic          r_shared_mode, n_shared_mode;
    logic [7:0]    r_nest, n_nest;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic [8:0]    r_mem [WAIT_DEPTH];
    logic [8:0]    r_rd_data;
    logic          w_push;
    logic [8:0]    w_push_data;
    logic [AW:0]   w_tail_sum;
    logic [AW:0]   w_tail_wrap;
    logic [AW-1:0] w_tail;
    logic          w_out_free;

    assign w_out_free  = !r_out_valid || i_res_ready;
    assign w_tail_sum  = {1'b0, r_head} + (AW + 1)'(r_fill);
    assign w_tail_wrap = (w_tail_sum >= DEPTH_S) ? (w_tail_sum - DEPTH_S) : w_tail_sum;
    assign w_tail      = w_tail_wrap[AW-1:0];
    assign w_push_data = {i_req.shared, i_req.task_id};

    always_comb begin
        n_state       = r_state;
        n_owner_task  = r_owner_task;
        n_owner_valid = r_owner_valid;
        n_shared_mode = r_shared_mode;
        n_nest        = r_nest;
        n_head        = r_head;
        n_fill        = r_fill;
        n_out_valid   = r_out_valid && !i_res_ready;
        n_out         = r_out;
        o_req_pop     = 1'b0;
        w_push        = 1'b0;

        unique case (r_state)
            S_EXEC: begin
                if (i_req_valid && w_out_free) begin
                    o_req_pop         = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.woken_valid  = 1'b0;
                    n_out.woken_task   = 8'd0;
                    n_out.woken_shared = 1'b0;
                    n_out.status       = ST_REFUSED;
                    unique case (i_req.kind)
                        K_ACQUIRE: begin
                            if (r_nest == 8'd0) begin
                                n_shared_mode = i_req.shared;
                                n_owner_valid = !i_req.shared;
                                n_owner_task  = i_req.shared ? 8'd0 : i_req.task_id;
                                n_nest        = 8'd1;
                                n_out.status  = ST_GRANTED;
                            end else if ((r_owner_valid && r_owner_task == i_req.task_id) ||
                                         (i_req.shared && !r_owner_valid)) begin
                                if (r_nest != NEST_MAX) begin
                                    n_nest = r_nest + 8'd1;
                                end
                                n_out.status = ST_GRANTED;
                            end else if (!i_req.blocking) begin
                                n_out.status = ST_REFUSED;
                            end else if (r_fill == DEPTH_F) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_push       = 1'b1;
                                n_fill       = r_fill + FW'(1);
                                n_out.status = ST_QUEUED;
                            end
                        end
                        K_RELEASE: begin
                            if (r_nest == 8'd0) begin
                                n_out.status = ST_CORRUPT;
                            end else if (r_nest != 8'd1) begin
                                n_nest       = r_nest - 8'd1;
                                n_out.status = ST_HELD;
                            end else if (r_fill != '0) begin
                                // Go to S_WAKE for the registered head entry read
                                n_out_valid = r_out_valid && !i_res_ready;
                                n_out       = r_out;
                                n_state     = S_WAKE;
                            end else begin
                                n_owner_task  = 8'd0;
                                n_owner_valid = 1'b0;
                                n_shared_mode = 1'b0;
                                n_nest        = 8'd0;
                                n_out.status  = ST_FREE;
                            end
                        end
                        default: begin
                            n_out.status = ST_REFUSED;
                        end
                    endcase
                    n_out.nest_level = n_nest;
                    n_out.lock_mode  = (n_nest == 8'd0) ? LM_FREE :
                                       (n_shared_mode ? LM_SHARED : LM_EXCLUSIVE);
                end
            end
            S_WAKE: begin
                if (w_out_free) begin
                    n_shared_mode      = r_rd_data[8];
                    n_owner_valid      = !r_rd_data[8];
                    n_owner_task       = r_rd_data[8] ? 8'd0 : r_rd_data[7:0];
                    n_nest             = 8'd1;
                    n_head             = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                    n_fill             = r_fill - FW'(1);
                    n_out_valid        = 1'b1;
                    n_out.status       = ST_HANDED;
                    n_out.woken_valid  = 1'b1;
                    n_out.woken_task   = r_rd_data[7:0];
                    n_out.woken_shared = r_rd_data[8];
                    n_out.nest_level   = 8'd1;
                    n_out.lock_mode    = r_rd_data[8] ? LM_SHARED : LM_EXCLUSIVE;
                    n_state            = S_EXEC;
                end
            end
            default: begin
                n_state = S_EXEC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_tail] <= w_push_data;
        end
        r_rd_data <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_EXEC;
            r_owner_task  <= 8'd0;
            r_owner_valid <= 1'b0;
            r_shared_mode <= 1'b0;
            r_nest        <= 8'd0;
            r_head        <= '0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_owner_task  <= n_owner_task;
            r_owner_valid <= n_owner_valid;
            r_shared_mode <= n_shared_mode;
            r_nest        <= n_nest;
            r_head        <= n_head;
            r_fill        <= n_fill;
            r_out_valid   <= n_out_valid;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

@@ hw/rtl/nested_shared_lock_manager_unit.sv @@
// Top level of the nested shared lock manager: stream ports, front decode queue, back executor.
// Depends on nslm_pkg, nslm_front and nslm_back.
// Flow: a request is registered in the front queue, then the back end applies it and registers the
//   result; a release that hands the lock to a waiter also passes through S_WAKE for the waiter memory read.
// Rate: one request per cycle unless the result stream stalls or a handing release is in S_WAKE.
// Reset: synchronous, active low; clears the lock and queue pointers, not the waiter memory.
`timescale 1ns / 1ps

module nested_shared_lock_manager_unit
    import nslm_pkg::*;
#(
    parameter int WAIT_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [2:0] opcode, [10:3] task_id, [15:11] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] status, [3] woken_valid, [11:4] woken_task, [12] woken_shared,
    // [14:13] lock_mode, [22:15] nest_level, [23] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic    w_req_valid;
    t_req    w_req;
    logic    w_req_pop;
    t_result w_res;

    // Decode each request transaction and hold it in a short queue
    nslm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_opcode    (i_s_axis_tdata[2:0]),
        .i_task_id   (i_s_axis_tdata[10:3]),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_pop   (w_req_pop)
    );

    // Apply requests to the lock state and register the result
    nslm_back #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_pop   (w_req_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (i_m_axis_tready)
    );

    // Pack the result, zero fill to whole bytes
    assign o_m_axis_tdata = {1'b0, w_res};

endmodule

@@ tb/sv/nested_shared_lock_manager_unit_tb.sv @@
// Self-checking testbench for nested_shared_lock_manager_unit: stream stimulus, a lock predictor
// and an in-order scoreboard of expected result transactions.
// Depends on nslm_pkg and the top level RTL only.
`timescale 1ns / 1ps

module nested_shared_lock_manager_unit_tb;
    import nslm_pkg::*;

    localparam int WAIT_DEPTH     = 16;
    localparam int REQUEST_TARGET = 1550;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TAIL_CYCLES    = 16;

    // Predicts the lock state for every accepted request and checks results in order.
    class lock_scoreboard;
        logic [7:0] owner_task;
        bit         owner_valid;
        bit         shared_mode;
        logic [7:0] nest_count;
        logic [8:0] waiters[$];     // bit 8 shared, bits 7..0 task
        t_result    expected_q[$];
        int         depth;
        int         errors;

        function new(int depth_i);
            depth       = depth_i;
            owner_task  = '0;
            owner_valid = 1'b0;
            shared_mode = 1'b0;
            nest_count  = '0;
            errors      = 0;
        endfunction

        function void grant_fresh(bit shared, logic [7:0] tid);
            shared_mode = shared;
            owner_valid = !shared;
            owner_task  = shared ? 8'd0 : tid;
            nest_count  = 8'd1;
        endfunction

        function void note_request(logic [2:0] op, logic [7:0] tid);
            t_result    r;
            bit         shared;
            bit         blocking;
            logic [8:0] head;
            r        = '0;
            r.status = ST_REFUSED;
            case (op)
                OP_OBTAIN_EX, OP_ATTEMPT_EX, OP_OBTAIN_SH, OP_ATTEMPT_SH: begin
                    shared   = (op == OP_OBTAIN_SH) || (op == OP_ATTEMPT_SH);
                    blocking = (op == OP_OBTAIN_EX) || (op == OP_OBTAIN_SH);
                    if (nest_count == 0) begin
                        grant_fresh(shared, tid);
                        r.status = ST_GRANTED;
                    end else if ((owner_valid && owner_task == tid) ||
                                 (shared && !owner_valid)) begin
                        // nesting grant; the count sticks at its maximum
                        if (nest_count != NEST_MAX) nest_count++;
                        r.status = ST_GRANTED;
                    end else if (!blocking) begin
                        r.status = ST_REFUSED;
                    end else if (waiters.size() >= depth) begin
                        r.status = ST_FULL;
                    end else begin
                        waiters.push_back({shared, tid});
                        r.status = ST_QUEUED;
                    end
                end
                OP_RELEASE: begin
                    if (nest_count == 0) begin
                        r.status = ST_CORRUPT;
                    end else begin
                        nest_count--;
                        if (nest_count != 0) begin
                            r.status = ST_HELD;
                        end else if (waiters.size() != 0) begin
                            head           = waiters.pop_front();
                            r.woken_valid  = 1'b1;
                            r.woken_task   = head[7:0];
                            r.woken_shared = head[8];
                            grant_fresh(head[8], head[7:0]);
                            r.status = ST_HANDED;
                        end else begin
                            owner_task  = '0;
                            owner_valid = 1'b0;
                            shared_mode = 1'b0;
                            r.status    = ST_FREE;
                        end
                    end
                end
                default: r.status = ST_REFUSED;
            endcase
            r.lock_mode  = (nest_count == 0) ? LM_FREE : (shared_mode ? LM_SHARED : LM_EXCLUSIVE);
            r.nest_level = nest_count;
            expected_q.push_back(r);
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data);
            t_result got;
            t_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result transaction 0x%06h arrived with no request pending", data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            got   = t_result'(data[$bits(t_result)-1:0]);
            check_field("status",       exp_r.status,       got.status);
            check_field("woken_valid",  exp_r.woken_valid,  got.woken_valid);
            check_field("woken_task",   exp_r.woken_task,   got.woken_task);
            check_field("woken_shared", exp_r.woken_shared, got.woken_shared);
            check_field("lock_mode",    exp_r.lock_mode,    got.lock_mode);
            check_field("nest_level",   exp_r.nest_level,   got.nest_level);
            check_field("pad",          0,                  data[OUT_DATA_W-1]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    // [2:0] opcode, [10:3] task_id, [15:11] zero
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // [2:0] status, [3] woken_valid, [11:4] woken_task, [12] woken_shared,
    // [14:13] lock_mode, [22:15] nest_level, [23] zero
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    lock_scoreboard sb = new(WAIT_DEPTH);

    int unsigned requests_sent = 0;
    int unsigned burst_end = 0;      // sender runs without gaps until this count
    logic [7:0]  task_pool[4];
    int unsigned idle_cycles = 0;

    nested_shared_lock_manager_unit #(
        .WAIT_DEPTH(WAIT_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Favor a small pool so that owners come back; use the whole id range now and then.
    function automatic logic [7:0] pick_task();
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return task_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [2:0] pick_acquire_op();
        case ($urandom_range(0, 3))
            0:       return OP_OBTAIN_EX;
            1:       return OP_ATTEMPT_EX;
            2:       return OP_OBTAIN_SH;
            default: return OP_ATTEMPT_SH;
        endcase
    endfunction

    // Weight releases heavily so the lock keeps cycling between held and free.
    function automatic logic [2:0] pick_any_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return OP_OBTAIN_EX;
        if (r < 32) return OP_ATTEMPT_EX;
        if (r < 60) return OP_RELEASE;
        if (r < 74) return OP_OBTAIN_SH;
        if (r < 88) return OP_ATTEMPT_SH;
        return 3'($urandom_range(5, 7));
    endfunction

    function automatic void refresh_pool();
        foreach (task_pool[k]) task_pool[k] = 8'($urandom_range(0, 255));
    endfunction

    // Present one request at a falling edge, hold it until the transaction completes,
    // then log it with the predictor. Keep tvalid high when no gap follows.
    task automatic send_request(input logic [2:0] op, input logic [7:0] tid);
        int unsigned gap;
        gap = (requests_sent < burst_end) ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  <= {5'd0, tid, op};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(op, tid);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every pending result has been returned.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Release until the lock is free, slipping in stray requests now and then.
    task automatic release_until_free();
        while (sb.nest_count != 0) begin
            if ($urandom_range(0, 4) == 0) send_request(pick_any_op(), pick_task());
            send_request(OP_RELEASE, pick_task());
        end
    endtask

    // Receiver: short ready windows broken by stalls, plus long stall-free stretches.
    initial begin
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 300)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
                i_m_axis_tready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge i_clk);
            end
        end
    end

    // Check every result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
    end

    // Watchdog: abort when neither side completes a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $error("no transaction for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] holder;
        int unsigned choice;
        int unsigned count;

        refresh_pool();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corrupt release, undefined opcodes, shared nesting by any task,
        // refusals, queueing of exclusive waiters and exclusive handoff.
        send_request(OP_RELEASE,    8'h00);
        send_request(3'd5,          8'hFF);
        send_request(3'd6,          8'hAA);
        send_request(3'd7,          8'h55);
        send_request(OP_ATTEMPT_SH, 8'h55);
        send_request(OP_OBTAIN_SH,  8'hAA);
        send_request(OP_ATTEMPT_EX, 8'h01);
        send_request(OP_OBTAIN_EX,  8'hFF);
        send_request(OP_OBTAIN_SH,  8'h00);
        send_request(OP_RELEASE,    8'h12);
        send_request(OP_RELEASE,    8'h34);
        send_request(OP_OBTAIN_SH,  8'hFF);
        send_request(OP_ATTEMPT_EX, 8'hFF);
        send_request(OP_ATTEMPT_SH, 8'h10);
        send_request(OP_OBTAIN_EX,  8'hFF);
        send_request(OP_RELEASE,    8'hFF);
        send_request(OP_RELEASE,    8'hFF);
        send_request(OP_RELEASE,    8'hFF);
        send_request(OP_RELEASE,    8'hFF);
        send_request(OP_RELEASE,    8'h00);
        send_request(OP_OBTAIN_EX,  8'h80);
        send_request(OP_RELEASE,    8'h80);
        drain_results();

        // Nest past the ceiling, park one waiter behind it, then unwind to a handoff.
        send_request(OP_OBTAIN_EX, 8'h3C);
        repeat (260) send_request(pick_acquire_op(), 8'h3C);
        send_request(OP_OBTAIN_SH, 8'hC3);
        release_until_free();

        // Fill the waiter queue and push past it.
        send_request(OP_ATTEMPT_EX, 8'h5A);
        for (int k = 0; k < WAIT_DEPTH + 2; k++) begin
            send_request(($urandom_range(0, 1) != 0) ? OP_OBTAIN_EX : OP_OBTAIN_SH, 8'(k));
        end
        send_request(OP_ATTEMPT_SH, 8'h77);
        release_until_free();
        drain_results();

        // Random: mostly well-formed hold/nest/queue/unwind sequences, some noise.
        while (requests_sent < REQUEST_TARGET) begin
            refresh_pool();
            choice = $urandom_range(0, 9);
            if (choice < 3) begin
                repeat ($urandom_range(8, 32)) send_request(pick_any_op(), pick_task());
            end else if (choice < 8) begin
                if (sb.nest_count != 0) release_until_free();
                holder = pick_task();
                send_request(pick_acquire_op(), holder);
                repeat ($urandom_range(0, 4)) send_request(pick_acquire_op(), holder);
                count = $urandom_range(0, WAIT_DEPTH + 2);
                repeat (count) begin
                    if ($urandom_range(0, 5) == 0) send_request(pick_acquire_op(), pick_task());
                    else send_request(($urandom_range(0, 1) != 0) ? OP_OBTAIN_EX : OP_OBTAIN_SH,
                                      pick_task());
                end
                release_until_free();
            end else if (choice == 8) begin
                drain_results();
            end else begin
                burst_end = requests_sent + $urandom_range(30, 80);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
